FILE: hdl/ctxb_pkg.sv
// Shared types, constants and key ROM for the chained table XOR byte cipher.
package ctxb_pkg;

	// Chain seed and key ROM length
	localparam logic [7:0] ChainSeed = 8'h53;
	localparam int         KeyLen    = 87;
	localparam int         KeyPosW   = 7;

	// Checksum term constants
	localparam logic [7:0]  TermXorEven = 8'h35;
	localparam logic [7:0]  TermXorOdd  = 8'h80;
	localparam logic [15:0] TermSub     = 16'd7;

	// Checksum phase codes (byte position mod 4)
	localparam logic [1:0] PhaseXor35  = 2'd0;
	localparam logic [1:0] PhaseNonZro = 2'd1;
	localparam logic [1:0] PhaseXor80  = 2'd2;
	localparam logic [1:0] PhaseSub7   = 2'd3;

	// Key ROM
	localparam logic [7:0] KeyRom [0:KeyLen-1] = '{
		8'h51, 8'h37, 8'h41, 8'hde, 8'hed, 8'h37, 8'h42, 8'hca, 8'hac, 8'haa,
		8'h39, 8'hab, 8'h58, 8'h37, 8'h12, 8'hfd, 8'h2a, 8'hcc, 8'h5f, 8'h55,
		8'h85, 8'h91, 8'h73, 8'hcf, 8'ha2, 8'h33, 8'hbb, 8'hf4, 8'haa, 8'h77,
		8'hcc, 8'h45, 8'h78, 8'h99, 8'h03, 8'h40, 8'h79, 8'hac, 8'hfe, 8'h50,
		8'hcc, 8'hdd, 8'hde, 8'h50, 8'h12, 8'hd2, 8'he8, 8'h57, 8'h1c, 8'hdf,
		8'h33, 8'h2f, 8'h0e, 8'h48, 8'hd0, 8'he1, 8'h13, 8'h9e, 8'h42, 8'hf3,
		8'h74, 8'h61, 8'h78, 8'h8b, 8'ha1, 8'h78, 8'h77, 8'h3c, 8'hdd, 8'h64,
		8'h09, 8'h49, 8'h53, 8'hf3, 8'h82, 8'h17, 8'ha5, 8'h49, 8'haa, 8'hf1,
		8'h96, 8'h90, 8'h07, 8'hcd, 8'h11, 8'h88, 8'h21
	};

	// One input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       payload_start;
		logic       payload_end;
	} ctxb_item_t;

	// One result item
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] running_sum;
		logic        is_last;
	} ctxb_result_t;

endpackage

FILE: hdl/ctxb_core.sv
// Cipher datapath: chain, key index, checksum state and the per-byte transform.
module ctxb_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic                  direction,
	input  ctxb_pkg::ctxb_item_t   item,
	output ctxb_pkg::ctxb_result_t result
);
	import ctxb_pkg::*;

	logic [7:0]         prev_plain_q;
	logic [KeyPosW-1:0] key_pos_q;
	logic [1:0]         phase_q;
	logic [15:0]        sum_q;

	logic [7:0]         eff_prev;
	logic [KeyPosW-1:0] eff_pos;
	logic [1:0]         eff_phase;
	logic [15:0]        eff_sum;
	logic [7:0]         mixed;
	logic [7:0]         plain;
	logic [15:0]        term;
	logic [15:0]        sum_next;
	logic [KeyPosW-1:0] pos_next;

	// Start flag reseeds the state seen by this byte
	always_comb begin
		eff_prev  = item.payload_start ? ChainSeed : prev_plain_q;
		eff_pos   = item.payload_start ? '0 : key_pos_q;
		eff_phase = item.payload_start ? '0 : phase_q;
		eff_sum   = item.payload_start ? '0 : sum_q;
	end

	// Transform: the XOR mix is the output in both directions
	always_comb begin
		mixed = item.data_byte ^ eff_prev ^ KeyRom[eff_pos];
		plain = direction ? mixed : item.data_byte;
	end

	// Checksum term by position
	always_comb begin
		case (eff_phase)
			PhaseXor35:  term = {8'h00, plain ^ TermXorEven};
			PhaseNonZro: term = {15'd0, (plain != 8'h00)};
			PhaseXor80:  term = {8'h00, plain ^ TermXorOdd};
			PhaseSub7:   term = {8'h00, plain} - TermSub;
			default:     term = '0;
		endcase
		sum_next = eff_sum + term;
		pos_next = (eff_pos == KeyPosW'(KeyLen - 1)) ? '0 : eff_pos + 1'b1;
	end

	// State update per transferred byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_plain_q <= ChainSeed;
			key_pos_q    <= '0;
			phase_q      <= '0;
			sum_q        <= '0;
		end else if (fire) begin
			prev_plain_q <= plain;
			key_pos_q    <= pos_next;
			phase_q      <= eff_phase + 1'b1;
			sum_q        <= sum_next;
		end
	end

	assign result.out_byte    = mixed;
	assign result.running_sum = sum_next;
	assign result.is_last     = item.payload_end;

endmodule

FILE: hdl/chained_table_xor_byte_cipher.sv
// Top level: input register, cipher datapath and result register.
// One byte is taken per cycle unless the input side stalls; each byte passes
// through the input register, then the result register. Throughput is one byte
// a cycle, set by the single XOR step that updates the chain register. The input
// side stalls only when its register is full and the result register is both
// full and stalled. The direction register must be written while no byte is in
// flight; it applies to the next byte processed.
module chained_table_xor_byte_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        payload_start,
	input  logic        payload_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [15:0] running_sum,
	output logic        is_last
);
	import ctxb_pkg::*;

	logic         direction_q;
	logic         valid_s1;
	ctxb_item_t   item_s1;
	logic         out_valid_q;
	ctxb_result_t res_q;
	ctxb_result_t res;
	logic         fire;
	logic         in_xfer;

	// Stage 1 advances when the result register is free or being drained
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign in_xfer  = in_valid && !in_stall;

	// Direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_wr_en) begin
			direction_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.data_byte     <= data_byte;
			item_s1.payload_start <= payload_start;
			item_s1.payload_end   <= payload_end;
		end
	end

	ctxb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.direction (direction_q),
		.item      (item_s1),
		.result    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = res_q.out_byte;
	assign running_sum = res_q.running_sum;
	assign is_last     = res_q.is_last;

`ifndef SYNTHESIS
	// A held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !fire)
		else $error("result register overwritten while stalled");

	// First byte of an encrypted payload starts the checksum at byte ^ 0x35
	a_start_sum: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.payload_start && !direction_q |=>
			running_sum == {8'h00, $past(item_s1.data_byte) ^ TermXorEven})
		else $error("checksum not reseeded on payload start");

	// First byte of a payload uses the chain seed and key entry 0
	a_start_byte: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.payload_start |=>
			out_byte == ($past(item_s1.data_byte) ^ ChainSeed ^ KeyRom[0]))
		else $error("chain or key index not reseeded on payload start");
`endif

endmodule
